// ===== rtl/bdar_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the button debouncer with auto-repeat.
// Depends on nothing; every other file in rtl uses it by scoped names.
package bdar_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IGNORE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PER   = 2'd2;

  localparam logic [CFG_W-1:0] RST_IGNORE       = 16'd250;
  localparam logic [CFG_W-1:0] RST_REPEAT_DELAY = 16'd1000;
  localparam logic [CFG_W-1:0] RST_REPEAT_PER   = 16'd100;

  typedef struct packed {
    logic [CFG_W-1:0] ignore_ms;
    logic [CFG_W-1:0] repeat_delay_ms;
    logic [CFG_W-1:0] repeat_period_ms;
  } cfg_t;

  // Per-button result of one scan.
  typedef struct packed {
    logic chg;
    logic stable;
    logic rep;
  } lane_res_t;

endpackage

// ===== rtl/bdar_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file for the debouncer: three 16-bit timing registers.
// Depends on bdar_pkg.
module bdar_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bdar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdar_pkg::CFG_W-1:0]     cfg_data,
  output bdar_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ignore_ms        <= bdar_pkg::RST_IGNORE;
      cfg.repeat_delay_ms  <= bdar_pkg::RST_REPEAT_DELAY;
      cfg.repeat_period_ms <= bdar_pkg::RST_REPEAT_PER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdar_pkg::REG_IGNORE:       cfg.ignore_ms        <= cfg_data;
        bdar_pkg::REG_REPEAT_DELAY: cfg.repeat_delay_ms  <= cfg_data;
        bdar_pkg::REG_REPEAT_PER:   cfg.repeat_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/bdar_lane.sv =====
`timescale 1ns / 1ps
// One button lane: debounce window, stable level and auto-repeat timing state.
// Depends on bdar_pkg.
module bdar_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        pin,
  input  logic [bdar_pkg::TIME_W-1:0] now,
  input  bdar_pkg::cfg_t              cfg,
  output bdar_pkg::lane_res_t         res
);

  logic                        stable;
  logic                        rep;
  logic [bdar_pkg::TIME_W-1:0] ign_stamp;
  logic [bdar_pkg::TIME_W-1:0] rep_stamp;

  logic                        stable_next;
  logic                        rep_next;
  logic                        chg;
  logic [bdar_pkg::TIME_W-1:0] ign_stamp_next;
  logic [bdar_pkg::TIME_W-1:0] rep_stamp_next;
  logic [bdar_pkg::TIME_W-1:0] ign_elapsed;
  logic [bdar_pkg::TIME_W-1:0] rep_elapsed;
  logic [bdar_pkg::TIME_W-1:0] ignore_w;
  logic                        held;

  assign ignore_w    = {{(bdar_pkg::TIME_W-bdar_pkg::CFG_W){1'b0}}, cfg.ignore_ms};
  assign ign_elapsed = now - ign_stamp;
  assign rep_elapsed = now - rep_stamp;
  assign held        = ign_elapsed < ignore_w;

  always_comb begin
    stable_next    = stable;
    rep_next       = rep;
    chg            = 1'b0;
    ign_stamp_next = ign_stamp;
    rep_stamp_next = rep_stamp;
    if (!held) begin
      stable_next = pin;
      if (stable != pin) begin
        chg            = 1'b1;
        ign_stamp_next = now;
        if (pin) begin
          rep_next = 1'b0;
        end else begin
          rep_stamp_next = now;
        end
      end else begin
        // A quiet button keeps its window already expired.
        ign_stamp_next = now - ignore_w;
        if (!pin) begin
          if (rep) begin
            if (rep_elapsed >= {{(bdar_pkg::TIME_W-bdar_pkg::CFG_W){1'b0}},
                                cfg.repeat_period_ms}) begin
              chg            = 1'b1;
              rep_stamp_next = now;
            end
          end else if (rep_elapsed >= {{(bdar_pkg::TIME_W-bdar_pkg::CFG_W){1'b0}},
                                       cfg.repeat_delay_ms}) begin
            rep_next       = 1'b1;
            chg            = 1'b1;
            rep_stamp_next = now;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable    <= 1'b1;
      rep       <= 1'b0;
      ign_stamp <= '0;
      rep_stamp <= '0;
    end else if (step) begin
      stable    <= stable_next;
      rep       <= rep_next;
      ign_stamp <= ign_stamp_next;
      rep_stamp <= rep_stamp_next;
    end
  end

  assign res.chg    = chg;
  assign res.stable = stable_next;
  assign res.rep    = rep_next;

endmodule

// ===== rtl/button_debounce_autorepeat.sv =====
`timescale 1ns / 1ps
// Top level of the five-button debouncer with auto-repeat.
// Depends on bdar_pkg, bdar_regs and bdar_lane.
//
//   Channel  Handshake                 Payload
//   in       in_valid / in_ready       pin_levels[4:0], now_ms[31:0]
//   out      out_valid / out_ready     changed[4:0], stable_levels[4:0], repeating[4:0]
//   cfg      cfg_we (no wait)          cfg_index[1:0], cfg_data[15:0]
//
// An accepted scan item lands in the input register. Once the result register is free
// or being emptied, the lane logic moves the item into it and raises out_valid.
// While out_ready stays high, the block accepts one item per cycle.
// The lane logic sets only the clock period: per button it has two 32-bit
// subtract-and-compare paths and one 32-bit subtract that backdates the window.
// Reset (synchronous, active high) marks all buttons released, clears repeat
// state, zeroes every time stamp and loads the register reset values.
// When the result is not taken, the input register still holds one more item.
// in_ready drops only when both stages are full and out_ready is low.
module button_debounce_autorepeat (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bdar_pkg::NUM_BUTTONS-1:0] pin_levels,
  input  logic [bdar_pkg::TIME_W-1:0]      now_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bdar_pkg::NUM_BUTTONS-1:0] changed,
  output logic [bdar_pkg::NUM_BUTTONS-1:0] stable_levels,
  output logic [bdar_pkg::NUM_BUTTONS-1:0] repeating,
  input  logic                             cfg_we,
  input  logic [bdar_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdar_pkg::CFG_W-1:0]       cfg_data
);

  bdar_pkg::cfg_t cfg;

  // Input register stage.
  logic                             s1_valid;
  logic [bdar_pkg::NUM_BUTTONS-1:0] s1_pins;
  logic [bdar_pkg::TIME_W-1:0]      s1_now;

  // The result register is free, or is being emptied this cycle.
  logic advance;
  logic step;

  bdar_pkg::lane_res_t lane_res [bdar_pkg::NUM_BUTTONS];

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  // Button state moves forward exactly when the staged item enters the result register.
  assign step     = s1_valid && advance;

  bdar_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  for (genvar i = 0; i < bdar_pkg::NUM_BUTTONS; i++) begin : g_lane
    bdar_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .step (step),
      .pin  (s1_pins[i]),
      .now  (s1_now),
      .cfg  (cfg),
      .res  (lane_res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pins <= pin_levels;
      s1_now  <= now_ms;
    end
  end

  for (genvar i = 0; i < bdar_pkg::NUM_BUTTONS; i++) begin : g_out
    always_ff @(posedge clk) begin
      if (step) begin
        changed[i]       <= lane_res[i].chg;
        stable_levels[i] <= lane_res[i].stable;
        repeating[i]     <= lane_res[i].rep;
      end
    end
  end

  // Auto-repeat is only ever active on a button whose stable level is pressed.
  a_rep_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((repeating & stable_levels) == '0))
    else $error("repeating flag set on a released button");

  // With the result register empty, the block always takes a new item.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // A staged item behind a stalled result is neither lost nor replaced.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> (s1_valid && $stable(s1_now)))
    else $error("staged item lost during output stall");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule

// ===== verif/button_debounce_autorepeat_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for button_debounce_autorepeat: scan items, results, register writes.
// Depends on bdar_pkg and the RTL top level; a scoreboard class predicts each scan result.
module button_debounce_autorepeat_tb;

  localparam int NB = bdar_pkg::NUM_BUTTONS;

  // The block has three registers. Index 3 is decoded by nobody, and a write to it
  // must leave the configuration alone.
  localparam logic [bdar_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Nothing is accepted while the sender waits for the block to drain. Nothing is
  // accepted while the registers are written. The drain at the end also accepts
  // nothing.
  localparam int WATCHDOG_LIMIT = 1000;

  // What one scan produces, as the scoreboard stores it.
  typedef struct packed {
    logic [NB-1:0] chg;
    logic [NB-1:0] stable;
    logic [NB-1:0] rep;
  } scan_res_t;

  // Predicts every scan from a private copy of the debounce state and the registers.
  // Each accepted scan queues one expected result. Each result taken from the block
  // is compared with the oldest entry in that queue.
  class debounce_board;
    bdar_pkg::cfg_t cfg;
    logic [NB-1:0] stable_q;
    logic [NB-1:0] repeat_on;
    logic [31:0]   ignore_at [NB];
    logic [31:0]   repeat_at [NB];
    scan_res_t     expected_q [$];
    int            errors;

    function new();
      cfg.ignore_ms        = bdar_pkg::RST_IGNORE;
      cfg.repeat_delay_ms  = bdar_pkg::RST_REPEAT_DELAY;
      cfg.repeat_period_ms = bdar_pkg::RST_REPEAT_PER;
      stable_q  = '1;
      repeat_on = '0;
      foreach (ignore_at[i]) begin
        ignore_at[i] = '0;
        repeat_at[i] = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(logic [bdar_pkg::CFG_IDX_W-1:0] idx, logic [bdar_pkg::CFG_W-1:0] data);
      case (idx)
        bdar_pkg::REG_IGNORE:       cfg.ignore_ms = data;
        bdar_pkg::REG_REPEAT_DELAY: cfg.repeat_delay_ms = data;
        bdar_pkg::REG_REPEAT_PER:   cfg.repeat_period_ms = data;
        default: ;
      endcase
    endfunction

    function void note_scan(logic [NB-1:0] pins, logic [31:0] now);
      logic [NB-1:0] held;
      logic [NB-1:0] chg;
      logic [31:0]   since;
      scan_res_t     res;
      held = '0;
      for (int i = 0; i < NB; i++) begin
        since = now - ignore_at[i];
        held[i] = since < {16'h0, cfg.ignore_ms};
      end
      chg      = (stable_q ^ pins) & ~held;
      stable_q = (stable_q & held) | (pins & ~held);
      for (int i = 0; i < NB; i++) begin
        if (!held[i]) begin
          if (chg[i]) begin
            ignore_at[i] = now;
            if (stable_q[i])
              repeat_on[i] = 1'b0;
            else
              repeat_at[i] = now;
          end else begin
            // A quiet button backdates its window so that its next edge counts at once.
            ignore_at[i] = now - {16'h0, cfg.ignore_ms};
            if (!stable_q[i]) begin
              since = now - repeat_at[i];
              if (repeat_on[i]) begin
                if (since >= {16'h0, cfg.repeat_period_ms}) begin
                  chg[i] = 1'b1;
                  repeat_at[i] = now;
                end
              end else if (since >= {16'h0, cfg.repeat_delay_ms}) begin
                repeat_on[i] = 1'b1;
                chg[i] = 1'b1;
                repeat_at[i] = now;
              end
            end
          end
        end
      end
      res.chg    = chg;
      res.stable = stable_q;
      res.rep    = repeat_on;
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task check_result(logic [NB-1:0] chg, logic [NB-1:0] stable, logic [NB-1:0] rep);
      scan_res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no scan pending: changed %b stable %b repeating %b",
                         chg, stable, rep));
      end else begin
        want = expected_q.pop_front();
        if (chg !== want.chg)
          report($sformatf("changed %b, expected %b", chg, want.chg));
        if (stable !== want.stable)
          report($sformatf("stable_levels %b, expected %b", stable, want.stable));
        if (rep !== want.rep)
          report($sformatf("repeating %b, expected %b", rep, want.rep));
      end
    endtask
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_ready;
  logic [NB-1:0]                    pin_levels;
  logic [bdar_pkg::TIME_W-1:0]      now_ms;
  logic                             out_valid;
  logic                             out_ready = 1'b1;
  logic [NB-1:0]                    changed;
  logic [NB-1:0]                    stable_levels;
  logic [NB-1:0]                    repeating;
  logic                             cfg_we;
  logic [bdar_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [bdar_pkg::CFG_W-1:0]       cfg_data;

  debounce_board db = new();

  // The sender idles before an item with probability idle_pct percent. The receiver
  // starts a stall with probability stall_pct percent. Both come in bursts.
  int          idle_pct;
  int          stall_pct;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  logic [31:0] cur_now;

  button_debounce_autorepeat dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_levels   (pin_levels),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .changed      (changed),
    .stable_levels(stable_levels),
    .repeating    (repeating),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver side. out_ready changes only at the falling edge. A new stall can
  // start only after the previous one has ended.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Results are sampled at the rising edge. The values read here are the ones from
  // before the edge, so the order of processes within the time step does not matter.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      db.check_result(changed, stable_levels, repeating);
  end

  // The watchdog ends a hung run. It counts consecutive cycles in which neither
  // channel accepts an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // This task offers one scan and holds it until the block accepts it. When the
  // previous item was also sent back to back, in_valid is simply left high.
  task send_scan(logic [NB-1:0] pins, logic [31:0] now);
    @(negedge clk);
    in_valid   <= 1'b1;
    pin_levels <= pins;
    now_ms     <= now;
    do @(posedge clk); while (!in_ready);
    db.note_scan(pins, now);
  endtask

  // This task may insert a random gap before the next item. The gap starts at the
  // falling edge after the last acceptance, so in_valid is never lowered and raised
  // again in the same time step.
  task pace();
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task write_reg(logic [bdar_pkg::CFG_IDX_W-1:0] idx, logic [bdar_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    db.write_reg(idx, data);
  endtask

  // Registers are written only while the block is empty. The sender stops first and
  // waits for every pending result, so that the input and result registers are both
  // empty. Then all four indexes are written; the unused one gets random data.
  task apply_cfg(logic [15:0] ign, logic [15:0] dly, logic [15:0] per);
    @(negedge clk);
    in_valid <= 1'b0;
    while (db.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(bdar_pkg::REG_IGNORE, ign);
    write_reg(bdar_pkg::REG_REPEAT_DELAY, dly);
    write_reg(bdar_pkg::REG_REPEAT_PER, per);
    write_reg(REG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // This task runs one random phase. Most scans hold a button pattern for a while,
  // so that debounce windows expire and auto-repeat starts and runs. Time steps are
  // scaled to the largest register. Into this run go single flipped buttons,
  // one-scan bounces, and now and then a scan with random pins and a random time
  // jump. That random jump can go backwards.
  task run_phase(int n_items, logic [15:0] ign, logic [15:0] dly, logic [15:0] per);
    logic [NB-1:0] pattern;
    logic [NB-1:0] pins;
    logic [NB-1:0] mask;
    int unsigned   step_max;
    int            pick;
    int            b;
    apply_cfg(ign, dly, per);
    step_max = ign;
    if (dly > step_max) step_max = dly;
    if (per > step_max) step_max = per;
    step_max = step_max / 3 + 4;
    pattern = NB'($urandom);
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      cur_now = cur_now + $urandom_range(0, step_max);
      pins = pattern;
      if (pick < 8) begin
        b = $urandom_range(0, NB - 1);
        pattern[b] = ~pattern[b];
        pins = pattern;
      end else if (pick < 14) begin
        mask = NB'($urandom_range(1, (1 << NB) - 1));
        pins = pattern ^ mask;
      end else if (pick < 17) begin
        pins = NB'($urandom);
        cur_now = $urandom;
      end
      pace();
      send_scan(pins, cur_now);
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    pin_levels = '0;
    now_ms     = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idle_pct   = 30;
    stall_pct  = 30;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The directed part runs with the reset register values: ignore 250, delay 1000,
    // period 100. First, the early scans after reset. All stamps start at zero, so
    // every button is ignored until now reaches 250.
    send_scan(5'b00000, 32'd0);
    pace();
    send_scan(5'b00000, 32'd249);
    // Button 0 is pressed. A bounce inside its window is ignored.
    send_scan(5'b11110, 32'd250);
    send_scan(5'b11111, 32'd260);
    pace();
    // The button is held: one scan just short of the repeat delay, one exactly on it.
    // Then one scan just short of a repeat period, and one exactly on it.
    send_scan(5'b11110, 32'd1249);
    send_scan(5'b11110, 32'd1250);
    send_scan(5'b11110, 32'd1349);
    send_scan(5'b11110, 32'd1350);
    // A release clears repeating.
    send_scan(5'b11111, 32'd1400);
    pace();
    // All five buttons are pressed together. The quiet buttons were backdated, so their
    // press is taken at once, button 0 aside. Then time runs up to the wrap and past it.
    send_scan(5'b00000, 32'd1500);
    send_scan(5'b00000, 32'hFFFF_FFF0);
    send_scan(5'b00000, 32'h0000_0010);
    send_scan(5'b00000, 32'h0000_0060);
    send_scan(5'b11111, 32'h0000_0100);
    // Alternating buttons are pressed. Then a jump backwards in time, which looks
    // like a very long time has passed.
    send_scan(5'b01010, 32'h8000_0000);
    send_scan(5'b10101, 32'h7FFF_FFFF);
    pace();
    send_scan(5'b11111, 32'hFFFF_FFFF);
    send_scan(5'b00000, 32'hFFFF_FFFF);

    // The random phases go through the register extremes and a spread of settings.
    // Every phase starts with an idle pause and a full set of register writes.
    cur_now = 32'h0000_2000;
    idle_pct = 25; stall_pct = 25;
    run_phase(190, 16'd0, 16'd0, 16'd0);
    run_phase(190, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    idle_pct = 40; stall_pct = 40;
    run_phase(190, 16'd20, 16'd100, 16'd10);
    idle_pct = 15; stall_pct = 15;
    run_phase(190, 16'($urandom_range(1, 300)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 200)));
    // This phase brings now_ms through its wrap again, with the reset settings.
    cur_now = 32'hFFFF_F000;
    idle_pct = 25; stall_pct = 25;
    run_phase(190, bdar_pkg::RST_IGNORE, bdar_pkg::RST_REPEAT_DELAY, bdar_pkg::RST_REPEAT_PER);
    // In the last part both sides run at full rate.
    idle_pct = 0; stall_pct = 0;
    run_phase(190, 16'd5, 16'd60, 16'd7);

    @(negedge clk);
    in_valid <= 1'b0;
    while (db.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (db.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== button_debounce_autorepeat.f =====
rtl/bdar_pkg.sv
rtl/bdar_regs.sv
rtl/bdar_lane.sv
rtl/button_debounce_autorepeat.sv
verif/button_debounce_autorepeat_tb.sv
